@@ rtl/gsp_pkg.sv @@
// Package for the gas sensor ppm converter: widths, codes, curve constants
// and the elaboration-time square-root table used by the exp2 stages.
// Depends on nothing.
package gsp_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int IN_W        = 12;
	localparam int CO2_W       = 20;
	localparam int NH4_W       = 24;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 12;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CALIB   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGHRES = 2'd1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_CAL   = 2'd3;

	// item class decided at the input stage
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_OK   = 2'd0;
	localparam kind_t KIND_CAL  = 2'd1;
	localparam kind_t KIND_ZERO = 2'd2;
	localparam kind_t KIND_FULL = 2'd3;

	localparam logic [10:0] FULL_SCALE = 11'd1024;
	localparam logic [17:0] K_CO2      = 18'd188865;
	localparam logic [17:0] K_NH4      = 18'd162620;
	localparam logic [10:0] CO2_BASE   = 11'd408;
	localparam logic [10:0] NH4_BASE   = 11'd1280;
	localparam logic [23:0] CO2_MAX    = 24'd1048575;
	localparam logic [23:0] NH4_MAX    = 24'd16777215;

	function automatic logic [63:0] isqrt64(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] rem;
		logic [63:0] bitv;
		res  = '0;
		rem  = v;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv = bitv >> 2;
		while (bitv != 64'd0) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// 2^(2^-j) in Q30, by repeated truncating square roots of 2.0
	function automatic logic [30:0] root_q30(int j);
		logic [63:0] t;
		t = 64'd2 << 30;
		for (int i = 1; i <= j; i++)
			t = isqrt64(t << 30);
		return t[30:0];
	endfunction

endpackage

@@ rtl/gsp_sample_if.sv @@
// Input channel of the gas sensor converter: one converter sample per request.
// Depends on gsp_pkg.
interface gsp_sample_if;
	logic                         valid;
	logic                         ready;
	logic [gsp_pkg::IN_W-1:0]     adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink   (input valid, input adc_sample, output ready);
endinterface

@@ rtl/gsp_result_if.sv @@
// Result channel of the gas sensor converter: concentrations and status.
// Depends on gsp_pkg.
interface gsp_result_if;
	logic                           valid;
	logic                           ready;
	logic [gsp_pkg::CO2_W-1:0]      co2_ppm;
	logic [gsp_pkg::NH4_W-1:0]      nh4_ppm_q8;
	logic [gsp_pkg::STATUS_W-1:0]   status;

	modport source (output valid, output co2_ppm, output nh4_ppm_q8, output status,
		input ready);
	modport sink   (input valid, input co2_ppm, input nh4_ppm_q8, input status,
		output ready);
endinterface

@@ rtl/gsp_cfg_if.sv @@
// Configuration write channel of the gas sensor converter.
// Depends on gsp_pkg.
interface gsp_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [gsp_pkg::CFG_IDX_W-1:0]     index;
	logic [gsp_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/gas_sensor_ppm_converter_core.sv @@
// Gas sensor ppm converter: power-law conversion of a chemiresistor divider
// reading to CO2 and NH4 concentration. Depends on gsp_pkg and the three
// channel interfaces.
//
// Usage:
//  - cfg: write calib_sample (index 0) and high_resolution (index 1) while
//    idle; cfg.ready is always high, unknown indexes are dropped.
//  - sample: one converter reading per request; result: one result per sample.
//  - The pipeline has 38 register stages: input scaling, normalize, 16 log2
//    squaring stages (two 31x31 multiplies each), subtract, exponent
//    multiply, 16 exp2 factor stages (two 31x31 multiplies each), base
//    multiply, shift/saturate.
//  - Throughput is one sample per cycle while sample.ready is high.
//  - When result.ready is low, the full output stage holds; earlier stages
//    keep advancing into empty slots, so sample.ready drops only once every
//    stage holds an item. Nothing is lost or repeated.
//  - Reset clears all stage valid bits and both registers to zero
//    (calibration zero reads as invalid, status 3).
module gas_sensor_ppm_converter_core #(
	parameter int SAMPLE_BITS = gsp_pkg::SAMPLE_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	gsp_cfg_if.sink       cfg,
	gsp_sample_if.sink    sample,
	gsp_result_if.source  result
);

	localparam int NST   = 38;
	localparam int SH    = SAMPLE_BITS - 10;
	localparam int ST_L0 = 1;   // normalize stage, feeds log slot 0
	localparam int ST_L  = 18;  // log difference
	localparam int ST_Y  = 19;  // exponent multiply, feeds exp slot 0
	localparam int ST_M  = 36;  // base multiply
	localparam int ST_O  = 37;  // output
	localparam logic [11:0] SMASK = 12'((1 << SAMPLE_BITS) - 1);

	// ---------------- configuration ----------------
	logic [11:0] calib_q;
	logic        hires_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q <= '0;
			hires_q <= 1'b0;
		end else if (cfg.valid) begin
			if (cfg.index == gsp_pkg::REG_CALIB)
				calib_q <= cfg.data[11:0];
			else if (cfg.index == gsp_pkg::REG_HIGHRES)
				hires_q <= cfg.data[0];
		end
	end

	// ---------------- pipeline control ----------------
	logic [NST-1:0]  vld_q;
	logic [NST-1:0]  adv;
	gsp_pkg::kind_t  kind_sp [0:NST-1];

	always_comb begin
		adv[NST-1] = !vld_q[NST-1] || result.ready;
		for (int i = NST - 2; i >= 0; i--)
			adv[i] = !vld_q[i] || adv[i+1];
	end

	assign sample.ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0])
				vld_q[0] <= sample.valid;
			for (int i = 1; i < NST; i++)
				if (adv[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	// ---------------- stage 1: scale, classify, products ----------------
	logic [11:0]     a_raw, c_raw, a_sc, c_sc;
	gsp_pkg::kind_t  kind_c;
	logic [19:0]     num_c, den_c;
	logic [19:0]     num_s1, den_s1;

	always_comb begin
		a_raw = sample.adc_sample & SMASK;
		c_raw = calib_q & SMASK;
		a_sc  = hires_q ? (a_raw >> SH) : a_raw;
		c_sc  = hires_q ? (c_raw >> SH) : c_raw;
		if (c_sc == 12'd0 || c_sc >= 12'(gsp_pkg::FULL_SCALE))
			kind_c = gsp_pkg::KIND_CAL;
		else if (a_sc == 12'd0)
			kind_c = gsp_pkg::KIND_ZERO;
		else if (a_sc >= 12'(gsp_pkg::FULL_SCALE))
			kind_c = gsp_pkg::KIND_FULL;
		else
			kind_c = gsp_pkg::KIND_OK;
		num_c = 20'(gsp_pkg::FULL_SCALE - 11'(c_sc[9:0])) * 20'(a_sc[9:0]);
		den_c = 20'(c_sc[9:0]) * 20'(gsp_pkg::FULL_SCALE - 11'(a_sc[9:0]));
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			kind_sp[0] <= kind_c;
			num_s1     <= num_c;
			den_s1     <= den_c;
		end
		for (int i = 1; i < NST; i++)
			if (adv[i])
				kind_sp[i] <= kind_sp[i-1];
	end

	// ---------------- stage 2: normalize to Q1.30 ----------------
	logic [4:0]  msb_n_c, msb_d_c;
	logic [30:0] zn_sl [0:16];
	logic [30:0] zd_sl [0:16];
	logic [15:0] fn_sl [0:16];
	logic [15:0] fd_sl [0:16];
	logic [4:0]  mn_sl [0:16];
	logic [4:0]  md_sl [0:16];

	always_comb begin
		msb_n_c = '0;
		msb_d_c = '0;
		for (int b = 0; b < 20; b++) begin
			if (num_s1[b])
				msb_n_c = 5'(b);
			if (den_s1[b])
				msb_d_c = 5'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_L0]) begin
			zn_sl[0] <= 31'(num_s1) << (5'd30 - msb_n_c);
			zd_sl[0] <= 31'(den_s1) << (5'd30 - msb_d_c);
			fn_sl[0] <= '0;
			fd_sl[0] <= '0;
			mn_sl[0] <= msb_n_c;
			md_sl[0] <= msb_d_c;
		end
	end

	// ---------------- log2 squaring stages ----------------
	for (genvar k = 1; k <= 16; k++) begin : g_log
		logic [61:0] sqn, sqd;
		always_comb begin
			sqn = 62'(zn_sl[k-1]) * 62'(zn_sl[k-1]);
			sqd = 62'(zd_sl[k-1]) * 62'(zd_sl[k-1]);
		end
		always_ff @(posedge clk) begin
			if (adv[ST_L0 + k]) begin
				zn_sl[k] <= sqn[61] ? sqn[61:31] : sqn[60:30];
				zd_sl[k] <= sqd[61] ? sqd[61:31] : sqd[60:30];
				fn_sl[k] <= {fn_sl[k-1][14:0], sqn[61]};
				fd_sl[k] <= {fd_sl[k-1][14:0], sqd[61]};
				mn_sl[k] <= mn_sl[k-1];
				md_sl[k] <= md_sl[k-1];
			end
		end
	end

	// ---------------- log difference, exponent ----------------
	logic signed [21:0] lg_s3;
	logic signed [40:0] yc_c, yn_c;
	localparam logic signed [18:0] KC = 19'(gsp_pkg::K_CO2);
	localparam logic signed [18:0] KN = 19'(gsp_pkg::K_NH4);

	always_ff @(posedge clk) begin
		if (adv[ST_L])
			lg_s3 <= $signed({1'b0, mn_sl[16], fn_sl[16]})
				- $signed({1'b0, md_sl[16], fd_sl[16]});
	end

	always_comb begin
		yc_c = lg_s3 * KC;
		yn_c = lg_s3 * KN;
	end

	logic [30:0]        pc_se [0:16];
	logic [30:0]        pn_se [0:16];
	logic [15:0]        fc_se [0:16];
	logic [15:0]        fh_se [0:16];
	logic signed [7:0]  nc_se [0:16];
	logic signed [7:0]  nn_se [0:16];

	always_ff @(posedge clk) begin
		if (adv[ST_Y]) begin
			pc_se[0] <= 31'd1 << 30;
			pn_se[0] <= 31'd1 << 30;
			fc_se[0] <= yc_c[31:16];
			fh_se[0] <= yn_c[31:16];
			nc_se[0] <= yc_c[39:32];
			nn_se[0] <= yn_c[39:32];
		end
	end

	// ---------------- exp2 factor stages ----------------
	for (genvar j = 1; j <= 16; j++) begin : g_exp
		localparam logic [30:0] ROOT = gsp_pkg::root_q30(j);
		logic [61:0] mc, mh;
		always_comb begin
			mc = 62'(pc_se[j-1]) * 62'(ROOT);
			mh = 62'(pn_se[j-1]) * 62'(ROOT);
		end
		always_ff @(posedge clk) begin
			if (adv[ST_Y + j]) begin
				pc_se[j] <= fc_se[j-1][16-j] ? mc[60:30] : pc_se[j-1];
				pn_se[j] <= fh_se[j-1][16-j] ? mh[60:30] : pn_se[j-1];
				fc_se[j] <= fc_se[j-1];
				fh_se[j] <= fh_se[j-1];
				nc_se[j] <= nc_se[j-1];
				nn_se[j] <= nn_se[j-1];
			end
		end
	end

	// ---------------- base multiply ----------------
	logic [41:0]       mc_s5, mn_s5;
	logic signed [7:0] nc_s5, nn_s5;

	always_ff @(posedge clk) begin
		if (adv[ST_M]) begin
			mc_s5 <= 42'(gsp_pkg::CO2_BASE) * 42'(pc_se[16]);
			mn_s5 <= 42'(gsp_pkg::NH4_BASE) * 42'(pn_se[16]);
			nc_s5 <= nc_se[16];
			nn_s5 <= nn_se[16];
		end
	end

	// ---------------- shift, saturate, output ----------------
	function automatic logic [24:0] fit_out(logic [41:0] m, logic signed [7:0] n,
		logic [23:0] mx);
		logic signed [9:0] s;
		logic [41:0]       v;
		s = 10'sd30 - 10'(n);
		if (n > 8'sd30)
			return {1'b1, mx};
		if (s >= 10'sd42)
			v = '0;
		else
			v = m >> s[5:0];
		if (v > 42'(mx))
			return {1'b1, mx};
		return {1'b0, v[23:0]};
	endfunction

	logic [24:0]                   fc_c, fh_c;
	logic [gsp_pkg::CO2_W-1:0]     co2_c, co2_s6;
	logic [gsp_pkg::NH4_W-1:0]     nh4_c, nh4_s6;
	logic [gsp_pkg::STATUS_W-1:0]  st_c, st_s6;

	always_comb begin
		fc_c = fit_out(mc_s5, nc_s5, gsp_pkg::CO2_MAX);
		fh_c = fit_out(mn_s5, nn_s5, gsp_pkg::NH4_MAX);
		case (kind_sp[ST_M])
			gsp_pkg::KIND_CAL: begin
				co2_c = '0;
				nh4_c = '0;
				st_c  = gsp_pkg::ST_CAL;
			end
			gsp_pkg::KIND_ZERO: begin
				co2_c = '0;
				nh4_c = '0;
				st_c  = gsp_pkg::ST_RANGE;
			end
			gsp_pkg::KIND_FULL: begin
				co2_c = gsp_pkg::CO2_MAX[19:0];
				nh4_c = gsp_pkg::NH4_MAX;
				st_c  = gsp_pkg::ST_RANGE;
			end
			default: begin
				co2_c = fc_c[19:0];
				nh4_c = fh_c[23:0];
				st_c  = (fc_c[24] || fh_c[24]) ? gsp_pkg::ST_SAT : gsp_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[ST_O]) begin
			co2_s6 <= co2_c;
			nh4_s6 <= nh4_c;
			st_s6  <= st_c;
		end
	end

	assign result.valid      = vld_q[ST_O];
	assign result.co2_ppm    = co2_s6;
	assign result.nh4_ppm_q8 = nh4_s6;
	assign result.status     = st_s6;

	// ---------------- assertions ----------------
	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> sample.ready)
		else $error("input stalled with empty output stage");

	a_cal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == gsp_pkg::ST_CAL
		|-> result.co2_ppm == '0 && result.nh4_ppm_q8 == '0)
		else $error("invalid calibration with nonzero result");

	a_range_vals: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == gsp_pkg::ST_RANGE && result.co2_ppm != '0
		|-> result.co2_ppm == gsp_pkg::CO2_MAX[19:0]
			&& result.nh4_ppm_q8 == gsp_pkg::NH4_MAX)
		else $error("range case with partial saturation");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> vld_q[0])
		else $error("accepted sample not captured");

endmodule
